// ===== hdl/u8dec_pkg.sv =====
// Shared types, constants and byte-classification functions for the UTF-8 decoder.
// Used by u8dec_ctrl, u8dec_dp and utf8_codepoint_decoder_top; no dependencies.
package u8dec_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 3;   // 0..4 held bytes

  localparam logic [CP_W-1:0] REPLACEMENT_CP = CP_W'(8'h3F);
  localparam logic [CP_W-1:0] END_CP         = '0;

  // Held bytes, element 0 is the front of the sequence.
  typedef logic [3:0][BYTE_W-1:0] buf_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_t;

  // Result of looking at the front of the held bytes.
  typedef struct packed {
    logic             emit;
    logic [CP_W-1:0]  cp;
    logic             bad;
    logic [LEN_W-1:0] adv;
  } step_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_byte;
    logic emit_step;
    logic emit_flush;
    logic emit_end;
    logic last;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_zero;
    logic out_free;
    logic step_emit;
    logic step_more;
    logic len_zero;
  } dp_stat_t;

  // Total sequence length announced by a front byte, 0 if it cannot start one.
  function automatic logic [LEN_W-1:0] seq_len(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] n;
    begin
      if ((b & 8'h80) == 8'h00)      n = 3'd1;
      else if ((b & 8'hE0) == 8'hC0) n = 3'd2;
      else if ((b & 8'hF0) == 8'hE0) n = 3'd3;
      else if ((b & 8'hF8) == 8'hF0) n = 3'd4;
      else                           n = 3'd0;
      return n;
    end
  endfunction

  function automatic logic is_cont(input logic [BYTE_W-1:0] b);
    return (b & 8'hC0) == 8'h80;
  endfunction

  // One decode decision on the front of the held bytes.
  function automatic step_t front_eval(input buf_t bytes, input logic [LEN_W-1:0] len);
    step_t            s;
    logic [LEN_W-1:0] need;
    logic             broken;
    begin
      need   = seq_len(bytes[0]);
      broken = 1'b0;
      for (int k = 1; k < 4; k++) begin
        if ((LEN_W'(k) < need) && (LEN_W'(k) < len) && !is_cont(bytes[k])) broken = 1'b1;
      end
      s.emit = 1'b0;
      s.cp   = REPLACEMENT_CP;
      s.bad  = 1'b0;
      s.adv  = '0;
      if (len == '0) begin
        s.emit = 1'b0;
      end else if (need == 3'd1) begin
        s.emit = 1'b1;
        s.cp   = CP_W'(bytes[0]);
        s.adv  = 3'd1;
      end else if ((need == 3'd0) || broken) begin
        s.emit = 1'b1;
        s.bad  = 1'b1;
        s.adv  = 3'd1;
      end else if (len < need) begin
        s.emit = 1'b0;           // valid prefix, wait for more
      end else begin
        s.emit = 1'b1;
        s.adv  = need;
        unique case (need)
          3'd2:    s.cp = {10'd0, bytes[0][4:0], bytes[1][5:0]};
          3'd3:    s.cp = {5'd0, bytes[0][3:0], bytes[1][5:0], bytes[2][5:0]};
          default: s.cp = {bytes[0][2:0], bytes[1][5:0], bytes[2][5:0], bytes[3][5:0]};
        endcase
      end
      return s;
    end
  endfunction

endpackage

// ===== hdl/utf8_codepoint_decoder_top.sv =====
// Top level of the UTF-8 code point decoder: controller plus datapath.
// Depends on u8dec_pkg, u8dec_ctrl and u8dec_dp.
//
// Takes one text byte per transfer on the in_ channel and delivers decoded
// code points on the out_ channel. ASCII bytes come out as they are; a 2, 3
// or 4 byte sequence is held until complete and then comes out assembled.
// A bad front byte or a broken sequence gives '?' (63) with out_malformed
// set, and the held bytes after it are decoded again in order, so one byte
// can produce up to four results. A zero byte ends the text: every held byte
// gives a flagged '?', followed by one result with out_end_of_text set and
// code point 0. out_last_of_run marks the final result caused by an input
// byte; a byte that only extends a pending sequence produces no result.
// Overlong forms, surrogates and values above 0x10FFFF pass unchecked.
// One byte is in flight at a time. The controller takes a byte only in
// its idle state and then passes through its run or flush state, where it
// emits the results the byte causes, before going back. Stalls on out_stall
// hold it there. The next byte is taken while the last result of the
// previous one still waits in the result register.
module utf8_codepoint_decoder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [u8dec_pkg::BYTE_W-1:0]   in_text_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [u8dec_pkg::CP_W-1:0]     out_code_point,
  output logic                           out_malformed,
  output logic                           out_end_of_text,
  output logic                           out_last_of_run
);

  u8dec_pkg::dp_cmd_t  cmd;
  u8dec_pkg::dp_stat_t stat;

  // sequencer: accept / step / flush decisions
  u8dec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // held bytes, front decode and result register
  u8dec_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_text_byte    (in_text_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_point  (out_code_point),
    .out_malformed   (out_malformed),
    .out_end_of_text (out_end_of_text),
    .out_last_of_run (out_last_of_run),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

// ===== hdl/u8dec_ctrl.sv =====
// Sequencer for the UTF-8 decoder: accepts bytes and steps the datapath
// one result per cycle while the output is not stalled. Depends on u8dec_pkg.
module u8dec_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  u8dec_pkg::dp_stat_t stat,
  output u8dec_pkg::dp_cmd_t  cmd
);

  u8dec_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= u8dec_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      u8dec_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (stat.in_zero) begin
            state_nxt = u8dec_pkg::ST_FLUSH;
          end else begin
            cmd.load_byte = 1'b1;
            state_nxt     = u8dec_pkg::ST_RUN;
          end
        end
      end
      u8dec_pkg::ST_RUN: begin
        if (!stat.step_emit) begin
          state_nxt = u8dec_pkg::ST_IDLE;   // incomplete sequence held
        end else if (stat.out_free) begin
          cmd.emit_step = 1'b1;
          cmd.last      = !stat.step_more;
          if (!stat.step_more) state_nxt = u8dec_pkg::ST_IDLE;
        end
      end
      u8dec_pkg::ST_FLUSH: begin
        if (stat.out_free) begin
          if (stat.len_zero) begin
            cmd.emit_end = 1'b1;
            cmd.last     = 1'b1;
            state_nxt    = u8dec_pkg::ST_IDLE;
          end else begin
            cmd.emit_flush = 1'b1;
          end
        end
      end
      default: state_nxt = u8dec_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/u8dec_dp.sv =====
// Datapath for the UTF-8 decoder: held-byte buffer, front decode and
// result register. Depends on u8dec_pkg.
module u8dec_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [u8dec_pkg::BYTE_W-1:0]         in_text_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [u8dec_pkg::CP_W-1:0]           out_code_point,
  output logic                                 out_malformed,
  output logic                                 out_end_of_text,
  output logic                                 out_last_of_run,
  input  u8dec_pkg::dp_cmd_t                   cmd,
  output u8dec_pkg::dp_stat_t                  stat
);

  u8dec_pkg::buf_t                  buf_r;
  logic [u8dec_pkg::LEN_W-1:0]      len_r;
  logic                             out_valid_r;
  logic [u8dec_pkg::CP_W-1:0]       cp_r;
  logic                             bad_r;
  logic                             eot_r;
  logic                             last_r;

  u8dec_pkg::step_t                 cur;
  u8dec_pkg::step_t                 nxt;
  u8dec_pkg::buf_t                  shifted;
  logic [u8dec_pkg::LEN_W-1:0]      len_left;
  logic                             out_free;

  always_comb begin
    cur      = u8dec_pkg::front_eval(buf_r, len_r);
    shifted  = u8dec_pkg::buf_t'(buf_r >> {cur.adv, 3'b000});
    len_left = len_r - cur.adv;
    nxt      = u8dec_pkg::front_eval(shifted, len_left);
    out_free = !out_valid_r || !out_stall;
  end

  assign stat.in_zero   = (in_text_byte == '0);
  assign stat.out_free  = out_free;
  assign stat.step_emit = cur.emit;
  assign stat.step_more = nxt.emit;
  assign stat.len_zero  = (len_r == '0);

  // buffer and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cmd.load_byte) begin
      len_r <= len_r + 3'd1;
    end else if (cmd.emit_step) begin
      len_r <= len_left;
    end else if (cmd.emit_flush) begin
      len_r <= len_r - 3'd1;
    end else if (cmd.emit_end) begin
      len_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      buf_r[len_r[1:0]] <= in_text_byte;
    end else if (cmd.emit_step) begin
      buf_r <= shifted;
    end else if (cmd.emit_flush) begin
      buf_r <= u8dec_pkg::buf_t'(buf_r >> u8dec_pkg::BYTE_W);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_step || cmd.emit_flush || cmd.emit_end) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      cp_r   <= cur.cp;
      bad_r  <= cur.bad;
      eot_r  <= 1'b0;
      last_r <= cmd.last;
    end else if (cmd.emit_flush) begin
      cp_r   <= u8dec_pkg::REPLACEMENT_CP;
      bad_r  <= 1'b1;
      eot_r  <= 1'b0;
      last_r <= cmd.last;
    end else if (cmd.emit_end) begin
      cp_r   <= u8dec_pkg::END_CP;
      bad_r  <= 1'b0;
      eot_r  <= 1'b1;
      last_r <= cmd.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_code_point  = cp_r;
  assign out_malformed   = bad_r;
  assign out_end_of_text = eot_r;
  assign out_last_of_run = last_r;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for utf8_codepoint_decoder_top: byte stream in, code points out.
// Depends on u8dec_pkg for widths and the replacement / end code points.
module testbench;

  localparam int CP_W          = u8dec_pkg::CP_W;
  localparam int BYTE_W        = u8dec_pkg::BYTE_W;
  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 9;
  localparam int RANDOM_ITEMS  = 360;
  localparam int SETTLE_CYCLES = 20;
  // Worst case per byte is roughly a long send gap plus four results, each
  // behind a long receiver stall; this is several times that over the run.
  localparam int CYCLE_LIMIT   = 200000;

  typedef logic [BYTE_W-1:0] text_byte_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            malformed;
    logic            end_of_text;
    logic            last_of_run;
  } decoded_t;

  // One input byte causes at most four results.
  typedef decoded_t [3:0] decoded_run_t;

  typedef struct packed {
    text_byte_t text_byte;
    logic       typed;         // 1: typed_result is the single expected result
    decoded_t   typed_result;
  } directed_row_t;

  logic       clk;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  text_byte_t in_text_byte = '0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [CP_W-1:0] out_code_point;
  logic       out_malformed;
  logic       out_end_of_text;
  logic       out_last_of_run;

  // Shadow of the decoder's held sequence bytes.
  text_byte_t held_bytes [0:2];
  int         held_count = 0;

  // Code points still owed by the block, oldest first.
  decoded_t   code_points_due [$];
  decoded_t   oldest_due;

  int errors         = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Directed part. Typed rows start with nothing held and give exactly one result;
  // every other row is checked against the decoder shadow.
  directed_row_t directed_rows [26] = '{
    '{8'h00, 1'b1, '{21'h000000, 1'b0, 1'b1, 1'b1}},  // end of an empty text
    '{8'h41, 1'b1, '{21'h000041, 1'b0, 1'b0, 1'b1}},  // plain ASCII
    '{8'h7F, 1'b1, '{21'h00007F, 1'b0, 1'b0, 1'b1}},  // top of ASCII
    '{8'h3F, 1'b1, '{21'h00003F, 1'b0, 1'b0, 1'b1}},  // literal '?', not flagged
    '{8'h80, 1'b1, '{21'h00003F, 1'b1, 1'b0, 1'b1}},  // stray continuation, low end
    '{8'hBF, 1'b1, '{21'h00003F, 1'b1, 1'b0, 1'b1}},  // stray continuation, high end
    '{8'hF8, 1'b1, '{21'h00003F, 1'b1, 1'b0, 1'b1}},  // invalid lead
    '{8'hFF, 1'b1, '{21'h00003F, 1'b1, 1'b0, 1'b1}},  // invalid lead, all ones
    '{8'hC3, 1'b0, '0},                               // two byte sequence
    '{8'hA9, 1'b0, '0},
    '{8'hE2, 1'b0, '0},                               // three byte sequence
    '{8'h82, 1'b0, '0},
    '{8'hAC, 1'b0, '0},
    '{8'hF7, 1'b0, '0},                               // widest code point
    '{8'hBF, 1'b0, '0},
    '{8'hBF, 1'b0, '0},
    '{8'hBF, 1'b0, '0},
    '{8'hF0, 1'b0, '0},                               // broken after two conts
    '{8'h80, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h41, 1'b0, '0},
    '{8'hE0, 1'b0, '0},                               // zero with bytes held
    '{8'h80, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hC0, 1'b0, '0},                               // overlong form of zero
    '{8'h80, 1'b0, '0}
  };

  utf8_codepoint_decoder_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_point  (out_code_point),
    .out_malformed   (out_malformed),
    .out_end_of_text (out_end_of_text),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Length a front byte announces; 0 when it cannot start a sequence.
  function automatic int lead_length(input text_byte_t b);
    casez (b)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 0;
    endcase
  endfunction

  // Decoder shadow: takes one accepted byte, updates the held bytes and
  // returns the results it causes in run, the count as the return value.
  function automatic int decode_text_byte(input text_byte_t b, output decoded_run_t run);
    text_byte_t      seq [0:3];
    int              n_seq;
    int              front;
    int              need;
    int              span;
    int              k;
    int              n;
    logic            broken;
    logic            waiting;
    logic [CP_W-1:0] cp;
    run   = '0;
    n     = 0;
    front = 0;
    for (k = 0; k < 3; k++) seq[k] = held_bytes[k];
    seq[3] = '0;
    n_seq  = held_count;
    if (b == '0) begin
      // Terminator: flag every held byte, then the end marker.
      for (k = 0; k < n_seq; k++) begin
        run[n] = '{u8dec_pkg::REPLACEMENT_CP, 1'b1, 1'b0, 1'b0};
        n++;
      end
      run[n] = '{u8dec_pkg::END_CP, 1'b0, 1'b1, 1'b0};
      n++;
      n_seq = 0;
    end else begin
      seq[n_seq] = b;
      n_seq++;
      waiting = 1'b0;
      while (front < n_seq && !waiting) begin
        need   = lead_length(seq[front]);
        span   = n_seq - front;
        broken = 1'b0;
        for (k = 1; k < need && k < span; k++) begin
          if (seq[front + k][7:6] != 2'b10) broken = 1'b1;
        end
        if (need == 1) begin
          run[n] = '{CP_W'(seq[front]), 1'b0, 1'b0, 1'b0};
          n++;
          front++;
        end else if (need == 0 || broken) begin
          // Replace the front byte only; the rest is decoded again.
          run[n] = '{u8dec_pkg::REPLACEMENT_CP, 1'b1, 1'b0, 1'b0};
          n++;
          front++;
        end else if (span < need) begin
          waiting = 1'b1;
        end else begin
          case (need)
            2:       cp = CP_W'(seq[front][4:0]);
            3:       cp = CP_W'(seq[front][3:0]);
            default: cp = CP_W'(seq[front][2:0]);
          endcase
          for (k = 1; k < need; k++) cp = {cp[CP_W-7:0], seq[front + k][5:0]};
          run[n] = '{cp, 1'b0, 1'b0, 1'b0};
          n++;
          front += need;
        end
      end
    end
    held_count = n_seq - front;
    for (k = 0; k < 3; k++) begin
      if (k < held_count) held_bytes[k] = seq[front + k];
      else                held_bytes[k] = '0;
    end
    if (n > 0) run[n - 1].last_of_run = 1'b1;
    return n;
  endfunction

  // Starts and ends at a falling edge. Random gaps first, then hold the byte
  // until the transfer happens; the shadow runs at that rising edge.
  task automatic send_text_byte(input text_byte_t b, input logic typed,
                                input decoded_t typed_result);
    decoded_run_t run;
    int           n;
    int           k;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid     <= 1'b0;
      in_text_byte <= text_byte_t'($urandom);
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    do @(posedge clk); while (in_stall);
    n = decode_text_byte(b, run);
    if (typed) code_points_due.push_back(typed_result);
    else for (k = 0; k < n; k++) code_points_due.push_back(run[k]);
    @(negedge clk);
  endtask

  // Hold off the sender until every owed code point has come out.
  task automatic wait_all_delivered();
    in_valid <= 1'b0;
    do @(negedge clk); while (code_points_due.size() != 0);
  endtask

  function automatic text_byte_t lead_byte(input int len);
    case (len)
      2:       return {3'b110, 5'($urandom)};
      3:       return {4'b1110, 4'($urandom)};
      default: return {5'b11110, 3'($urandom)};
    endcase
  endfunction

  // Mostly well-formed sequences with random payload bits; the rest is
  // terminators, raw noise and sequences cut short by a non-continuation.
  task automatic send_random_chunk(output int sent);
    text_byte_t chunk [$];
    int         kind;
    int         len;
    int         k;
    kind = $urandom_range(99);
    if (kind < 30) begin
      chunk.push_back(text_byte_t'($urandom_range(127, 1)));
    end else if (kind < 72) begin
      len = (kind < 45) ? 2 : (kind < 60) ? 3 : 4;
      chunk.push_back(lead_byte(len));
      for (k = 1; k < len; k++) chunk.push_back({2'b10, 6'($urandom)});
    end else if (kind < 78) begin
      chunk.push_back('0);
    end else if (kind < 90) begin
      chunk.push_back(text_byte_t'($urandom_range(255)));
    end else begin
      len = $urandom_range(4, 2);
      chunk.push_back(lead_byte(len));
      for (k = $urandom_range(len - 2); k > 0; k--) chunk.push_back({2'b10, 6'($urandom)});
      if ($urandom_range(1)) chunk.push_back(text_byte_t'($urandom_range(127)));
      else                   chunk.push_back({2'b11, 6'($urandom)});
    end
    foreach (chunk[k]) send_text_byte(chunk[k], 1'b0, '0);
    sent = chunk.size();
  endtask

  initial begin
    int random_sent;
    int sent;
    int phase;
    random_sent = 0;
    foreach (held_bytes[k]) held_bytes[k] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table, no idling on either side.
    foreach (directed_rows[i]) begin
      send_text_byte(directed_rows[i].text_byte, directed_rows[i].typed,
                     directed_rows[i].typed_result);
    end

    // Random part in four idling phases; each phase starts with the pipe drained.
    for (phase = 0; phase < 4; phase++) begin
      wait_all_delivered();
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      while (random_sent < (phase + 1) * RANDOM_ITEMS / 4) begin
        send_random_chunk(sent);
        random_sent += sent;
      end
    end

    // Collect the tail, then idle a while so stray results would show up.
    wait_all_delivered();
    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver back-pressure, changed on the falling edge like all inputs.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result checker: each transfer on the out_ channel against the oldest owed one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (code_points_due.size() == 0) begin
        $error("unexpected result: code_point %0h malformed %0b end_of_text %0b",
               out_code_point, out_malformed, out_end_of_text);
        errors++;
      end else begin
        oldest_due = code_points_due.pop_front();
        if (out_code_point !== oldest_due.code_point) begin
          $error("code_point: expected %0h, got %0h", oldest_due.code_point, out_code_point);
          errors++;
        end
        if (out_malformed !== oldest_due.malformed) begin
          $error("malformed: expected %0b, got %0b", oldest_due.malformed, out_malformed);
          errors++;
        end
        if (out_end_of_text !== oldest_due.end_of_text) begin
          $error("end_of_text: expected %0b, got %0b", oldest_due.end_of_text,
                 out_end_of_text);
          errors++;
        end
        if (out_last_of_run !== oldest_due.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", oldest_due.last_of_run,
                 out_last_of_run);
          errors++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

// ===== files.f =====
hdl/u8dec_pkg.sv
hdl/u8dec_ctrl.sv
hdl/u8dec_dp.sv
hdl/utf8_codepoint_decoder_top.sv
dv/testbench.sv
